// ----- design/bcem_pkg.sv -----
// Package: shared types and constants of the bytecode emitter with line marks
`timescale 1ns / 1ps

package bcem_pkg;

    localparam int CFG_W      = 8;
    localparam int LINE_LIMIT = 65535;

    localparam logic [CFG_W-1:0] EXT_OPCODE_RESET  = 8'd55;
    localparam logic [CFG_W-1:0] LINE_OPCODE_RESET = 8'd54;

    localparam logic REG_EXTENSION_OPCODE = 1'b0;
    localparam logic REG_LINE_OPCODE      = 1'b1;

    localparam logic CMD_EMIT     = 1'b0;
    localparam logic CMD_SET_LINE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HEAD,
        ST_EXT_BYTE,
        ST_LOW
    } ctrl_state_t;

    typedef enum logic [1:0] {
        SEL_EXT_OP,
        SEL_EXT_BYTE,
        SEL_OP,
        SEL_LOW
    } byte_sel_t;

    typedef struct packed {
        logic      load;
        logic      load_second;
        logic      dec_pairs;
        logic      out_load;
        logic      out_last;
        byte_sel_t sel;
    } emit_cmd_t;

    typedef struct packed {
        logic starts;
        logic out_free;
        logic pairs_zero;
        logic has_second;
    } emit_status_t;

endpackage

// ----- design/bytecode_emitter_with_line_marks_top.sv -----
// Top level: bytecode emitter with pending source-line marks
`timescale 1ns / 1ps

// One input transfer is either an emit command or a set-line command. The block
// takes a transfer, then sends the bytes it causes one per cycle, when the output
// is not stalled, through an output register: a pending line marker (up to four
// bytes), then the instruction (two bytes plus two per extension pair, at most
// ARG_BYTES-1 pairs). The controller walks extension pairs with a down counter,
// and output backpressure stalls the byte sequence. A new transfer is taken once
// the last byte of the previous one is in the output register. Configuration
// writes are registered and are meant for idle.
module bytecode_emitter_with_line_marks_top #(
    parameter int ARG_BYTES = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic                       cfg_index,
    input  logic [bcem_pkg::CFG_W-1:0] cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       command,
    input  logic [7:0]                 opcode,
    input  logic signed [31:0]         argument,
    input  logic signed [20:0]         line_value,
    input  logic                       flag_reset,
    input  logic                       flag_absolute,
    input  logic                       flag_force,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [7:0]                 out_byte,
    output logic                       last_byte
);

    bcem_pkg::emit_cmd_t    cmd;
    bcem_pkg::emit_status_t status;

    bcem_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    bcem_datapath #(
        .ARG_BYTES (ARG_BYTES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .command       (command),
        .opcode        (opcode),
        .argument      (argument),
        .line_value    (line_value),
        .flag_reset    (flag_reset),
        .flag_absolute (flag_absolute),
        .flag_force    (flag_force),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .out_byte      (out_byte),
        .last_byte     (last_byte)
    );

endmodule

// ----- design/bcem_datapath.sv -----
// Datapath: line state, instruction registers, pair counter and output register
`timescale 1ns / 1ps

module bcem_datapath #(
    parameter int ARG_BYTES = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bcem_pkg::emit_cmd_t         cmd,
    output bcem_pkg::emit_status_t      status,
    input  logic                        cfg_write,
    input  logic                        cfg_index,
    input  logic [bcem_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        command,
    input  logic [7:0]                  opcode,
    input  logic signed [31:0]          argument,
    input  logic signed [20:0]          line_value,
    input  logic                        flag_reset,
    input  logic                        flag_absolute,
    input  logic                        flag_force,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [7:0]                  out_byte,
    output logic                        last_byte
);

    localparam int VAL_W = (8 * ARG_BYTES > 32) ? 8 * ARG_BYTES : 32;
    localparam int NB    = VAL_W / 8;
    localparam int PW    = (ARG_BYTES > 1) ? $clog2(ARG_BYTES) : 1;
    localparam logic signed [20:0] LIMIT_S = 21'(bcem_pkg::LINE_LIMIT);

    function automatic logic [PW-1:0] pair_count(input logic signed [VAL_W-1:0] v);
        logic [PW-1:0] p;
        p = '0;
        if (v > 255)
        begin
            for (int k = 1; k < NB; k++)
            begin
                if (v[8*k +: 8] != 8'd0)
                begin
                    p = (k < ARG_BYTES) ? PW'(k) : PW'(ARG_BYTES - 1);
                end
            end
        end
        return p;
    endfunction

    logic [7:0]              ext_opcode_reg, ext_opcode_next;
    logic [7:0]              line_opcode_reg, line_opcode_next;
    logic signed [16:0]      previous_line_reg, previous_line_next;
    logic [15:0]             line_base_reg, line_base_next;
    logic signed [16:0]      pending_line_reg, pending_line_next;
    logic                    pending_valid_reg, pending_valid_next;
    logic [7:0]              cur_op_reg, cur_op_next;
    logic signed [VAL_W-1:0] cur_val_reg, cur_val_next;
    logic [PW-1:0]           pairs_reg, pairs_next;
    logic [7:0]              sec_op_reg, sec_op_next;
    logic signed [VAL_W-1:0] sec_val_reg, sec_val_next;
    logic [PW-1:0]           sec_pairs_reg, sec_pairs_next;
    logic                    has_second_reg, has_second_next;
    logic                    out_valid_reg, out_valid_next;
    logic [7:0]              out_byte_reg, out_byte_next;
    logic                    out_last_reg, out_last_next;

    logic signed [20:0]      line_sat;
    logic signed [16:0]      line_abs;
    logic signed [16:0]      line_rel;
    logic signed [VAL_W-1:0] arg_ext;
    logic signed [VAL_W-1:0] pend_ext;
    logic signed [VAL_W-1:0] abs_ext;

    always_comb
    begin
        line_sat = (line_value > LIMIT_S) ? LIMIT_S : line_value;
        line_abs = (line_sat < 21'sd1) ? 17'sd1 : line_sat[16:0];
        line_rel = line_sat[16:0] - $signed({1'b0, line_base_reg});
        arg_ext  = VAL_W'(argument);
        pend_ext = VAL_W'(pending_line_reg);
        abs_ext  = VAL_W'(line_abs);
    end

    always_comb
    begin
        ext_opcode_next    = ext_opcode_reg;
        line_opcode_next   = line_opcode_reg;
        previous_line_next = previous_line_reg;
        line_base_next     = line_base_reg;
        pending_line_next  = pending_line_reg;
        pending_valid_next = pending_valid_reg;
        cur_op_next        = cur_op_reg;
        cur_val_next       = cur_val_reg;
        pairs_next         = pairs_reg;
        sec_op_next        = sec_op_reg;
        sec_val_next       = sec_val_reg;
        sec_pairs_next     = sec_pairs_reg;
        has_second_next    = has_second_reg;
        out_valid_next     = out_valid_reg;
        out_byte_next      = out_byte_reg;
        out_last_next      = out_last_reg;

        if (cfg_write)
        begin
            unique case (cfg_index)
                bcem_pkg::REG_EXTENSION_OPCODE: ext_opcode_next  = cfg_data;
                bcem_pkg::REG_LINE_OPCODE:      line_opcode_next = cfg_data;
            endcase
        end

        if (cmd.load)
        begin
            has_second_next = 1'b0;
            if (command == bcem_pkg::CMD_EMIT)
            begin
                sec_op_next    = opcode;
                sec_val_next   = arg_ext;
                sec_pairs_next = pair_count(arg_ext);
                if (pending_valid_reg)
                begin
                    cur_op_next     = line_opcode_reg;
                    cur_val_next    = pend_ext;
                    pairs_next      = pair_count(pend_ext);
                    has_second_next = 1'b1;
                end
                else
                begin
                    cur_op_next  = opcode;
                    cur_val_next = arg_ext;
                    pairs_next   = pair_count(arg_ext);
                end
                pending_valid_next = 1'b0;
            end
            else
            begin
                cur_op_next  = line_opcode_reg;
                cur_val_next = abs_ext;
                pairs_next   = pair_count(abs_ext);
                priority if (flag_reset)
                begin
                    if (flag_absolute)
                    begin
                        previous_line_next = line_abs;
                    end
                    line_base_next     = 16'(line_abs - 17'sd1);
                    pending_valid_next = 1'b0;
                end
                else if (line_sat < 21'sd0)
                begin
                    previous_line_next = -17'sd1;
                    pending_valid_next = 1'b0;
                end
                else if (flag_force || line_sat[16:0] != previous_line_reg)
                begin
                    previous_line_next = line_sat[16:0];
                    pending_line_next  = line_rel;
                    pending_valid_next = 1'b1;
                end
            end
        end
        else if (cmd.load_second)
        begin
            cur_op_next     = sec_op_reg;
            cur_val_next    = sec_val_reg;
            pairs_next      = sec_pairs_reg;
            has_second_next = 1'b0;
        end
        else if (cmd.dec_pairs)
        begin
            pairs_next = pairs_reg - 1'b1;
        end

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            out_last_next  = cmd.out_last;
            unique case (cmd.sel)
                bcem_pkg::SEL_EXT_OP:   out_byte_next = ext_opcode_reg;
                bcem_pkg::SEL_EXT_BYTE: out_byte_next = 8'(cur_val_reg >> {pairs_reg, 3'b000});
                bcem_pkg::SEL_OP:       out_byte_next = cur_op_reg;
                bcem_pkg::SEL_LOW:      out_byte_next = cur_val_reg[7:0];
            endcase
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_opcode_reg    <= bcem_pkg::EXT_OPCODE_RESET;
            line_opcode_reg   <= bcem_pkg::LINE_OPCODE_RESET;
            previous_line_reg <= -17'sd1;
            line_base_reg     <= '0;
            pending_valid_reg <= 1'b0;
            pairs_reg         <= '0;
            has_second_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            ext_opcode_reg    <= ext_opcode_next;
            line_opcode_reg   <= line_opcode_next;
            previous_line_reg <= previous_line_next;
            line_base_reg     <= line_base_next;
            pending_valid_reg <= pending_valid_next;
            pairs_reg         <= pairs_next;
            has_second_reg    <= has_second_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pending_line_reg <= pending_line_next;
        cur_op_reg       <= cur_op_next;
        cur_val_reg      <= cur_val_next;
        sec_op_reg       <= sec_op_next;
        sec_val_reg      <= sec_val_next;
        sec_pairs_reg    <= sec_pairs_next;
        out_byte_reg     <= out_byte_next;
        out_last_reg     <= out_last_next;
    end

    always_comb
    begin
        status.starts     = (command == bcem_pkg::CMD_EMIT) || (flag_reset && flag_absolute);
        status.out_free   = !out_valid_reg || out_ready;
        status.pairs_zero = (pairs_reg == '0);
        status.has_second = has_second_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last_byte = out_last_reg;

    // no byte overwritten before its transfer
    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten");

    a_ext_byte_has_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && cmd.sel == bcem_pkg::SEL_EXT_BYTE) |-> (pairs_reg != '0))
        else $error("extension byte with no pair left");

    a_pending_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && command == bcem_pkg::CMD_EMIT) |=> !pending_valid_reg)
        else $error("pending line survived an emit");

endmodule

// ----- design/bcem_ctrl.sv -----
// Controller: sequences the bytes of one or two instructions per transfer
`timescale 1ns / 1ps

module bcem_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  bcem_pkg::emit_status_t status,
    output bcem_pkg::emit_cmd_t    cmd
);

    bcem_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bcem_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        in_ready        = 1'b0;
        cmd.load        = 1'b0;
        cmd.load_second = 1'b0;
        cmd.dec_pairs   = 1'b0;
        cmd.out_load    = 1'b0;
        cmd.out_last    = 1'b0;
        cmd.sel         = bcem_pkg::SEL_OP;

        unique case (state_reg)
            bcem_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (status.starts)
                    begin
                        state_next = bcem_pkg::ST_HEAD;
                    end
                end
            end
            bcem_pkg::ST_HEAD:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (!status.pairs_zero)
                    begin
                        cmd.sel    = bcem_pkg::SEL_EXT_OP;
                        state_next = bcem_pkg::ST_EXT_BYTE;
                    end
                    else
                    begin
                        cmd.sel    = bcem_pkg::SEL_OP;
                        state_next = bcem_pkg::ST_LOW;
                    end
                end
            end
            bcem_pkg::ST_EXT_BYTE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.sel       = bcem_pkg::SEL_EXT_BYTE;
                    cmd.dec_pairs = 1'b1;
                    state_next    = bcem_pkg::ST_HEAD;
                end
            end
            bcem_pkg::ST_LOW:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.sel      = bcem_pkg::SEL_LOW;
                    cmd.out_last = !status.has_second;
                    if (status.has_second)
                    begin
                        cmd.load_second = 1'b1;
                        state_next      = bcem_pkg::ST_HEAD;
                    end
                    else
                    begin
                        state_next = bcem_pkg::ST_IDLE;
                    end
                end
            end
        endcase
    end

    a_start_enters_head: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && status.starts) |=> (state_reg == bcem_pkg::ST_HEAD))
        else $error("emitting transfer did not start byte sequence");

endmodule

// ----- dv/tb_bytecode_emitter_with_line_marks_top.sv -----
// Testbench: directed table and randomized checks of the bytecode emitter with line marks
`timescale 1ns / 1ps

module tb_bytecode_emitter_with_line_marks_top;

    localparam int ARG_BYTES       = 4;
    localparam int N_DIRECTED      = 26;
    localparam int N_PHASES        = 6;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int SETTLE_CYCLES   = 20;
    localparam int CYCLE_LIMIT     = 1000000;

    typedef struct packed {
        logic        command;
        logic [7:0]  opcode;
        logic [31:0] argument;
        logic [20:0] line_value;
        logic        flag_reset;
        logic        flag_absolute;
        logic        flag_force;
    } cmd_t;

    // bytes are right-aligned, first byte of the stream in the highest used slot
    typedef struct packed {
        cmd_t        c;
        logic        typed;
        logic [3:0]  n;
        logic [95:0] bytes;
    } row_t;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
    } out_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_write;
    logic                       cfg_index;
    logic [bcem_pkg::CFG_W-1:0] cfg_data;
    logic                       in_valid;
    logic                       in_ready;
    logic                       command;
    logic [7:0]                 opcode;
    logic signed [31:0]         argument;
    logic signed [20:0]         line_value;
    logic                       flag_reset;
    logic                       flag_absolute;
    logic                       flag_force;
    logic                       out_valid;
    logic                       out_ready;
    logic [7:0]                 out_byte;
    logic                       last_byte;

    // predictor state
    logic [7:0]  ext_op;
    logic [7:0]  line_op;
    int          seen_line;
    logic [15:0] line_base;
    int          pend_line;
    bit          pend_valid;

    out_t stream_q[$];
    out_t head;
    bit   quiet;
    int   errors;
    int   cycle_count;

    bytecode_emitter_with_line_marks_top #(.ARG_BYTES(ARG_BYTES)) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .opcode        (opcode),
        .argument      (argument),
        .line_value    (line_value),
        .flag_reset    (flag_reset),
        .flag_absolute (flag_absolute),
        .flag_force    (flag_force),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .last_byte     (last_byte)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void put_instr(input logic [7:0] op, input int arg,
                                      inout logic [95:0] acc, inout int cnt);
        int          pairs;
        int          n;
        logic [31:0] ua;
        pairs = 0;
        n     = arg;
        ua    = arg;
        while (n > 255 && pairs < ARG_BYTES - 1)
        begin
            n = n / 256;
            pairs++;
        end
        while (pairs > 0)
        begin
            pairs--;
            acc = {acc[87:0], ext_op};
            acc = {acc[87:0], ua[8*(pairs+1) +: 8]};
            cnt += 2;
        end
        acc = {acc[87:0], op};
        acc = {acc[87:0], ua[7:0]};
        cnt += 2;
    endfunction

    function automatic void encode_command(input cmd_t c, output logic [95:0] seq,
                                           output int cnt);
        int ln;
        seq = '0;
        cnt = 0;
        if (c.command == bcem_pkg::CMD_EMIT)
        begin
            if (pend_valid)
            begin
                put_instr(line_op, pend_line, seq, cnt);
                pend_valid = 1'b0;
            end
            put_instr(c.opcode, int'(c.argument), seq, cnt);
        end
        else
        begin
            ln = {{11{c.line_value[20]}}, c.line_value};
            if (ln > bcem_pkg::LINE_LIMIT)
                ln = bcem_pkg::LINE_LIMIT;
            if (c.flag_reset)
            begin
                if (ln < 1)
                    ln = 1;
                if (c.flag_absolute)
                begin
                    put_instr(line_op, ln, seq, cnt);
                    seen_line = ln;
                end
                line_base  = 16'(ln - 1);
                pend_valid = 1'b0;
            end
            else if (ln < 0)
            begin
                seen_line  = -1;
                pend_valid = 1'b0;
            end
            else if (c.flag_force || ln != seen_line)
            begin
                seen_line  = ln;
                pend_line  = ln - int'(line_base);
                pend_valid = 1'b1;
            end
        end
    endfunction

    function automatic row_t mk_emit(input logic [7:0] op, input logic [31:0] arg,
                                     input logic typed, input int n,
                                     input logic [95:0] bytes);
        row_t r;
        r            = '0;
        r.c.command  = bcem_pkg::CMD_EMIT;
        r.c.opcode   = op;
        r.c.argument = arg;
        r.typed      = typed;
        r.n          = 4'(n);
        r.bytes      = bytes;
        return r;
    endfunction

    function automatic row_t mk_line(input logic [20:0] ln, input logic rst,
                                     input logic absl, input logic frc,
                                     input logic typed, input int n,
                                     input logic [95:0] bytes);
        row_t r;
        r                 = '0;
        r.c.command       = bcem_pkg::CMD_SET_LINE;
        r.c.line_value    = ln;
        r.c.flag_reset    = rst;
        r.c.flag_absolute = absl;
        r.c.flag_force    = frc;
        r.typed           = typed;
        r.n               = 4'(n);
        r.bytes           = bytes;
        return r;
    endfunction

    function automatic cmd_t rand_cmd();
        cmd_t c;
        c.command = ($urandom_range(0, 9) < 6) ? bcem_pkg::CMD_EMIT : bcem_pkg::CMD_SET_LINE;
        c.opcode  = 8'($urandom);
        case ($urandom_range(0, 5))
            0: c.argument = 32'($urandom_range(0, 255));
            1: c.argument = 32'($urandom_range(256, 65535));
            2: c.argument = 32'($urandom_range(0, 24'hFF_FFFF));
            3: c.argument = 32'($urandom);
            4: c.argument = 32'(-int'($urandom_range(1, 300)));
            default:
                case ($urandom_range(0, 8))
                    0: c.argument = 32'd0;
                    1: c.argument = 32'd255;
                    2: c.argument = 32'd256;
                    3: c.argument = 32'h0000_FFFF;
                    4: c.argument = 32'h0001_0000;
                    5: c.argument = 32'h00FF_FFFF;
                    6: c.argument = 32'h0100_0000;
                    7: c.argument = 32'h7FFF_FFFF;
                    default: c.argument = 32'h8000_0000;
                endcase
        endcase
        case ($urandom_range(0, 5))
            0: c.line_value = 21'($urandom_range(0, 600));
            1: c.line_value = 21'(seen_line);
            2: c.line_value = 21'($urandom);
            3: c.line_value = '1;
            4: c.line_value = 21'($urandom_range(65000, 70000));
            default: c.line_value = 21'(int'(line_base) + int'($urandom_range(0, 4)) - 2);
        endcase
        c.flag_reset    = ($urandom_range(0, 5) == 0);
        c.flag_absolute = 1'($urandom_range(0, 1));
        c.flag_force    = ($urandom_range(0, 3) == 0);
        return c;
    endfunction

    task automatic send_item(input cmd_t c, input logic typed, input int tn,
                             input logic [95:0] tbytes);
        logic [95:0] seq;
        int          cnt;
        out_t        ent;
        @(negedge clk);
        command       = c.command;
        opcode        = c.opcode;
        argument      = c.argument;
        line_value    = c.line_value;
        flag_reset    = c.flag_reset;
        flag_absolute = c.flag_absolute;
        flag_force    = c.flag_force;
        in_valid      = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        encode_command(c, seq, cnt);
        if (typed)
        begin
            seq = tbytes;
            cnt = tn;
        end
        for (int k = cnt - 1; k >= 0; k--)
        begin
            ent.b    = seq[8*k +: 8];
            ent.last = (k == 0);
            stream_q.push_back(ent);
        end
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat ($urandom_range(1, 18) - 1) @(negedge clk);
        end
    endtask

    task automatic drain_and_settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (stream_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic idx, input logic [7:0] val);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_write = 1'b0;
        if (idx == bcem_pkg::REG_EXTENSION_OPCODE)
            ext_op = val;
        else
            line_op = val;
    endtask

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (quiet || $urandom_range(0, 2) != 0)
            begin
                out_ready = 1'b1;
                repeat ($urandom_range(1, 12) - 1) @(negedge clk);
            end
            else
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 18) - 1) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (stream_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected transfer: expected none, actual byte %02h last %0b",
                         $time, out_byte, last_byte);
            end
            else
            begin
                head = stream_q.pop_front();
                if (out_byte !== head.b)
                begin
                    errors++;
                    $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                             $time, head.b, out_byte);
                end
                if (last_byte !== head.last)
                begin
                    errors++;
                    $display("%0t: last_byte mismatch: expected %0b, actual %0b",
                             $time, head.last, last_byte);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        row_t       directed [N_DIRECTED];
        logic [7:0] e_val;
        logic [7:0] l_val;

        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = bcem_pkg::REG_EXTENSION_OPCODE;
        cfg_data      = '0;
        in_valid      = 1'b0;
        command       = bcem_pkg::CMD_EMIT;
        opcode        = '0;
        argument      = '0;
        line_value    = '0;
        flag_reset    = 1'b0;
        flag_absolute = 1'b0;
        flag_force    = 1'b0;
        quiet         = 1'b0;
        errors        = 0;
        cycle_count   = 0;
        ext_op        = bcem_pkg::EXT_OPCODE_RESET;
        line_op       = bcem_pkg::LINE_OPCODE_RESET;
        seen_line     = -1;
        line_base     = '0;
        pend_line     = 0;
        pend_valid    = 1'b0;

        directed[0]  = mk_emit(8'h10, 32'd0, 1, 2, 96'h1000);
        directed[1]  = mk_emit(8'hFF, 32'd255, 1, 2, 96'hFFFF);
        directed[2]  = mk_emit(8'h01, 32'd256, 1, 4, 96'h3701_0100);
        directed[3]  = mk_emit(8'h02, 32'h7FFF_FFFF, 1, 8, 96'h377F_37FF_37FF_02FF);
        directed[4]  = mk_emit(8'h03, 32'hFFFF_FFFF, 1, 2, 96'h03FF);
        directed[5]  = mk_emit(8'h00, 32'h8000_0000, 1, 2, 96'h0000);
        directed[6]  = mk_line(21'd10, 0, 0, 0, 1, 0, '0);
        directed[7]  = mk_emit(8'h20, 32'd5, 1, 4, 96'h360A_2005);
        // same line again, no force: nothing pending
        directed[8]  = mk_line(21'd10, 0, 0, 0, 0, 0, '0);
        directed[9]  = mk_emit(8'h21, 32'd6, 1, 2, 96'h2106);
        directed[10] = mk_line(21'd10, 0, 0, 1, 0, 0, '0);
        directed[11] = mk_emit(8'h22, 32'h1234, 0, 0, '0);
        directed[12] = mk_line(21'd300, 1, 1, 0, 1, 4, 96'h3701_362C);
        directed[13] = mk_line(21'd299, 0, 0, 0, 0, 0, '0);
        directed[14] = mk_emit(8'h23, 32'd7, 0, 0, '0);
        // relative line of minus one stays pending
        directed[15] = mk_line(21'd298, 0, 0, 0, 0, 0, '0);
        directed[16] = mk_emit(8'h24, 32'd0, 0, 0, '0);
        directed[17] = mk_line(21'h1F_FFFF, 0, 0, 0, 0, 0, '0);
        directed[18] = mk_emit(8'h25, 32'd1, 0, 0, '0);
        directed[19] = mk_line(21'h0F_FFFF, 1, 1, 0, 1, 4, 96'h37FF_36FF);
        // absolute without reset, line below base
        directed[20] = mk_line(21'd0, 0, 1, 0, 0, 0, '0);
        directed[21] = mk_emit(8'h26, 32'd2, 0, 0, '0);
        directed[22] = mk_line(21'h10_0000, 0, 0, 1, 0, 0, '0);
        directed[23] = mk_line(-21'sd5, 1, 0, 1, 0, 0, '0);
        directed[24] = mk_line(21'd65535, 0, 0, 1, 0, 0, '0);
        directed[25] = mk_emit(8'hAB, 32'h1234_5678, 0, 0, '0);

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            send_item(directed[i].c, directed[i].typed, directed[i].n, directed[i].bytes);

        for (int p = 0; p < N_PHASES; p++)
        begin
            drain_and_settle();
            case (p)
                0:
                begin
                    e_val = 8'h00;
                    l_val = 8'hFF;
                end
                1:
                begin
                    e_val = 8'hFF;
                    l_val = 8'h00;
                end
                2:
                begin
                    e_val = 8'($urandom);
                    l_val = e_val;
                end
                default:
                begin
                    e_val = 8'($urandom);
                    l_val = 8'($urandom);
                end
            endcase
            write_config(bcem_pkg::REG_EXTENSION_OPCODE, e_val);
            write_config(bcem_pkg::REG_LINE_OPCODE, l_val);
            if (p == N_PHASES - 1)
                quiet = 1'b1;
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
                send_item(rand_cmd(), 1'b0, 0, '0);
        end

        drain_and_settle();
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- files.f -----
design/bcem_pkg.sv
design/bcem_datapath.sv
design/bcem_ctrl.sv
design/bytecode_emitter_with_line_marks_top.sv
dv/tb_bytecode_emitter_with_line_marks_top.sv
